/* hw/rtl/joint_to_motor_pwm_decoupler_macros.svh */
// Assertion helpers, clocked on the rising edge, disabled while reset is low.
`ifndef JOINT_TO_MOTOR_PWM_DECOUPLER_MACROS_SVH
`define JOINT_TO_MOTOR_PWM_DECOUPLER_MACROS_SVH

// Same-cycle implication.
`define JMPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JMPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/jmpd_pkg.sv */
`timescale 1ns / 1ps

package jmpd_pkg;

  // Motor slots provided by the board.
  localparam int unsigned MotorSlots = 4;
  localparam int unsigned OutMotors  = 4;

  // Item opcodes
  localparam logic OpStatus  = 1'b0;
  localparam logic OpCompute = 1'b1;

  // Board modes
  localparam logic [2:0] ModeShoulder = 3'd0;
  localparam logic [2:0] ModeWaist    = 3'd1;
  localparam logic [2:0] ModeUpperLeg = 3'd2;
  localparam logic [2:0] ModeAnkle    = 3'd3;
  localparam logic [2:0] ModeNone     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CfgBoardMode  = 2'd0;
  localparam logic [1:0] CfgMotorCount = 2'd1;
  localparam logic [1:0] CfgPwmLimit   = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  // Reset values
  localparam logic [2:0]  BoardModeRst  = ModeNone;
  localparam logic [2:0]  MotorCountRst = 3'd4;
  localparam logic [14:0] PwmLimitRst   = 15'h7fff;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         motor_index;
    logic               motor_error;
    logic signed [15:0] joint_pwm_0;
    logic signed [15:0] joint_pwm_1;
    logic signed [15:0] joint_pwm_2;
    logic signed [15:0] joint_pwm_3;
    logic               stiff_0;
    logic               stiff_1;
    logic               stiff_2;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] motor_pwm_0;
    logic signed [15:0] motor_pwm_1;
    logic signed [15:0] motor_pwm_2;
    logic signed [15:0] motor_pwm_3;
    logic [3:0]         halt_mask;
  } out_item_t;

endpackage

/* hw/rtl/jmpd_if.sv */
`timescale 1ns / 1ps

// Joint command channel.
interface jmpd_in_if;
  logic               valid;
  logic               ready;
  jmpd_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Motor command channel.
interface jmpd_out_if;
  logic                valid;
  logic                ready;
  jmpd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/joint_to_motor_pwm_decoupler.sv */
`timescale 1ns / 1ps
// Two register stages: a compute item passes the input register, then the result register, before out_o.
// Throughput: one item per cycle; a status item leaves the input register next cycle.
// Rate is set by the single result register, held while out_o stalls.
// Reset: board_mode none, motor_count 4, pwm_limit 32767, idle mask clear,
// both pipeline registers empty.
`include "joint_to_motor_pwm_decoupler_macros.svh"

module joint_to_motor_pwm_decoupler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  jmpd_in_if.sink                             in_i,
  jmpd_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [jmpd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [jmpd_pkg::CfgDataW-1:0]       cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0]  board_mode_q;
  logic [2:0]  motor_count_q;
  logic [14:0] pwm_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_mode_q  <= jmpd_pkg::BoardModeRst;
      motor_count_q <= jmpd_pkg::MotorCountRst;
      pwm_limit_q   <= jmpd_pkg::PwmLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jmpd_pkg::CfgBoardMode:  board_mode_q  <= cfg_data_i[2:0];
        jmpd_pkg::CfgMotorCount: motor_count_q <= cfg_data_i[2:0];
        jmpd_pkg::CfgPwmLimit:   pwm_limit_q   <= cfg_data_i[14:0];
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic               s1_valid_q, s1_valid_d;
  jmpd_pkg::in_item_t s1_q;
  logic               out_valid_q, out_valid_d;
  jmpd_pkg::out_item_t out_q, out_d;
  logic [3:0]         idle_mask_q, idle_mask_d;

  logic in_xfer, out_xfer, s1_adv, s1_status, in_ready;

  assign s1_status = (s1_q.opcode == jmpd_pkg::OpStatus);
  assign out_xfer  = out_valid_q & out_o.ready;
  // Status items never occupy the result register, so they always move on.
  assign s1_adv    = s1_valid_q & (s1_status | !out_valid_q | out_o.ready);
  assign in_ready  = !s1_valid_q | s1_adv;
  assign in_xfer   = in_i.valid & in_ready;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && !s1_status) begin
      out_valid_d = 1'b1;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  // Idle mask is updated as the status item retires, keeping item order.
  always_comb begin
    idle_mask_d = idle_mask_q;
    if (s1_adv && s1_status) begin
      idle_mask_d[s1_q.motor_index] = s1_q.motor_error;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      idle_mask_q <= 4'h0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      idle_mask_q <= idle_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_i.payload;
    end
    if (s1_adv && !s1_status) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Coupling arithmetic
  // ---------------------------------------------------------------------------
  // 65/40 reduces to 13/8: trunc(13*j/8), cut to 16 bits.
  function automatic logic signed [15:0] mul13_div8(input logic signed [15:0] j);
    logic signed [19:0] p;
    logic signed [19:0] b;
    p = (20'(j) <<< 3) + (20'(j) <<< 2) + 20'(j);
    b = p + (p[19] ? 20'sd7 : 20'sd0); // bias so the shift rounds toward zero
    return b[18:3];
  endfunction

  // 40/65 reduces to 8/13: magnitude divided by 13 through a reciprocal,
  // ceil(2^22/13) = 322639, exact for the 19-bit magnitudes seen here.
  function automatic logic signed [15:0] mul8_div13(input logic signed [15:0] j);
    logic [16:0] mag;
    logic [19:0] m;
    logic [38:0] prod;
    logic [15:0] q;
    mag  = j[15] ? (17'd0 - 17'(j)) : 17'(j);
    m    = {mag, 3'b000};
    prod = 39'(m) * 39'd322639;
    q    = prod[37:22];
    return j[15] ? (16'd0 - q) : q;
  endfunction

  // trunc((a +/- b)/2), cut to 16 bits.
  function automatic logic signed [15:0] half_trunc(input logic signed [16:0] s);
    logic signed [16:0] b;
    b = s + (s[16] ? 17'sd1 : 17'sd0);
    return b[16:1];
  endfunction

  logic signed [15:0] j0, j1, j2, j3;
  logic signed [15:0] mo [jmpd_pkg::OutMotors];
  logic signed [15:0] mc [jmpd_pkg::OutMotors];
  logic [3:0]         stop;
  logic signed [15:0] t, u;

  assign j0 = s1_q.joint_pwm_0;
  assign j1 = s1_q.joint_pwm_1;
  assign j2 = s1_q.joint_pwm_2;
  assign j3 = s1_q.joint_pwm_3;

  always_comb begin
    for (int k = 0; k < jmpd_pkg::OutMotors; k++) begin
      mo[k] = 16'sd0;
    end
    stop = 4'h0;
    t    = 16'sd0;
    u    = 16'sd0;
    case (board_mode_q)
      jmpd_pkg::ModeShoulder: begin
        if (|idle_mask_q[2:0]) begin
          stop[2:0] = 3'b111;
        end else begin
          mo[0] = j0;
          t     = s1_q.stiff_0 ? (16'sd0 - mul13_div8(j0)) : 16'sd0;
          mo[1] = t;
          mo[2] = t;
          if (s1_q.stiff_1) begin
            t     = mul13_div8(j1);
            mo[1] = mo[1] + t;
            mo[2] = mo[2] + t;
          end else begin
            mo[0] = mo[0] + j1;
            mo[1] = mo[1] + mul8_div13(j1);
          end
          if (s1_q.stiff_2) begin
            mo[2] = mo[2] + mul13_div8(j2);
          end else begin
            u     = mul8_div13(j2);
            mo[1] = mo[1] - u;
            mo[2] = mo[2] + u;
          end
        end
        if (idle_mask_q[3]) begin
          stop[3] = 1'b1;
        end else begin
          mo[3] = j3;
        end
      end
      jmpd_pkg::ModeWaist: begin
        if (|idle_mask_q[2:0]) begin
          stop[2:0] = 3'b111;
        end else begin
          mo[0] = half_trunc(17'(j0) - 17'(j1));
          mo[1] = half_trunc(17'(j0) + 17'(j1));
          mo[2] = j2;
        end
      end
      jmpd_pkg::ModeUpperLeg: begin
        if (idle_mask_q[0]) stop[0] = 1'b1; else mo[0] = j0;
        if (idle_mask_q[1]) stop[1] = 1'b1; else mo[1] = j1;
        if (idle_mask_q[2]) stop[2] = 1'b1; else mo[2] = j2;
        if (idle_mask_q[3]) stop[3] = 1'b1; else mo[3] = j3;
      end
      jmpd_pkg::ModeAnkle: begin
        if (idle_mask_q[0]) stop[0] = 1'b1; else mo[0] = j0;
        if (idle_mask_q[1]) stop[1] = 1'b1; else mo[1] = j1;
      end
      default: ; // none and unknown modes: all zero, no stop bits
    endcase
  end

  // Symmetric clamp on used motors; counts above the slots saturate.
  logic signed [16:0] lim_pos, lim_neg;
  assign lim_pos = signed'({2'b00, pwm_limit_q});
  assign lim_neg = 17'sd0 - lim_pos;

  always_comb begin
    for (int k = 0; k < jmpd_pkg::OutMotors; k++) begin
      mc[k] = mo[k];
      if ((32'(motor_count_q) > k) && (k < jmpd_pkg::MotorSlots)) begin
        if (17'(mo[k]) > lim_pos) begin
          mc[k] = lim_pos[15:0];
        end else if (17'(mo[k]) < lim_neg) begin
          mc[k] = lim_neg[15:0];
        end
      end
    end
  end

  always_comb begin
    out_d.motor_pwm_0 = mc[0];
    out_d.motor_pwm_1 = mc[1];
    out_d.motor_pwm_2 = mc[2];
    out_d.motor_pwm_3 = mc[3];
    out_d.halt_mask   = stop;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A result only appears from a compute item leaving the input register.
  `JMPD_ASSERT_IMPL(a_result_from_compute, clk_i, rst_ni, $rose(out_valid_q),
    $past(s1_valid_q && (s1_q.opcode == jmpd_pkg::OpCompute)), "result without compute item")

  // A retiring status item writes its idle bit.
  `JMPD_ASSERT_NEXT(a_status_updates_mask, clk_i, rst_ni, s1_adv && s1_status,
    idle_mask_q[$past(s1_q.motor_index)] == $past(s1_q.motor_error), "idle bit not updated")

  // Stopped motors carry a zero command.
  `JMPD_ASSERT_IMPL(a_stop_zero, clk_i, rst_ni, out_valid_q,
    (!out_q.halt_mask[0] || (out_q.motor_pwm_0 == 16'sd0)) &&
    (!out_q.halt_mask[1] || (out_q.motor_pwm_1 == 16'sd0)) &&
    (!out_q.halt_mask[2] || (out_q.motor_pwm_2 == 16'sd0)) &&
    (!out_q.halt_mask[3] || (out_q.motor_pwm_3 == 16'sd0)), "stopped motor not zero")

  // Motor 0 is within the limit whenever it is in use.
  `JMPD_ASSERT_IMPL(a_clamp_m0, clk_i, rst_ni, out_valid_q && (motor_count_q != 3'd0),
    (17'(out_q.motor_pwm_0) <= lim_pos) && (17'(out_q.motor_pwm_0) >= lim_neg),
    "motor 0 exceeds limit")

endmodule

/* tb/motor_pwm_checker.sv */
`timescale 1ns / 1ps

module motor_pwm_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  jmpd_in_if                            joint_i,
  jmpd_out_if                           motor_i,
  input  logic                          cfg_we_i,
  input  logic [jmpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jmpd_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  import jmpd_pkg::*;

  // Mirrored block state
  logic [2:0]  board_mode;
  logic [2:0]  motor_count;
  logic [14:0] pwm_limit;
  logic [3:0]  idle_mask;

  out_item_t motor_cmd_due[$];

  function automatic int wrap16(int v);
    logic signed [15:0] w;
    w = v[15:0];
    return w;
  endfunction

  function automatic out_item_t decouple_joints(in_item_t it);
    out_item_t  r;
    int         j[4];
    int         m[4];
    int         t;
    int         lim;
    int         used;
    int         span;
    logic [3:0] stop;
    j[0] = $signed(it.joint_pwm_0);
    j[1] = $signed(it.joint_pwm_1);
    j[2] = $signed(it.joint_pwm_2);
    j[3] = $signed(it.joint_pwm_3);
    m    = '{default: 0};
    stop = '0;
    case (board_mode)
      ModeShoulder: begin
        if (idle_mask[2:0] != 3'b000) begin
          stop[2:0] = 3'b111;
        end else begin
          m[0] = j[0];
          t    = it.stiff_0 ? wrap16((-65 * j[0]) / 40) : 0;
          m[1] = t;
          m[2] = t;
          if (it.stiff_1) begin
            t    = wrap16((65 * j[1]) / 40);
            m[1] = wrap16(m[1] + t);
            m[2] = wrap16(m[2] + t);
          end else begin
            m[0] = wrap16(m[0] + j[1]);
            m[1] = wrap16(m[1] + wrap16((40 * j[1]) / 65));
          end
          if (it.stiff_2) begin
            m[2] = wrap16(m[2] + wrap16((65 * j[2]) / 40));
          end else begin
            t    = wrap16((40 * j[2]) / 65);
            m[1] = wrap16(m[1] - t);
            m[2] = wrap16(m[2] + t);
          end
        end
        if (idle_mask[3]) stop[3] = 1'b1;
        else m[3] = j[3];
      end
      ModeWaist: begin
        if (idle_mask[2:0] != 3'b000) begin
          stop[2:0] = 3'b111;
        end else begin
          m[0] = wrap16((j[0] - j[1]) / 2);
          m[1] = wrap16((j[0] + j[1]) / 2);
          m[2] = j[2];
        end
      end
      ModeUpperLeg, ModeAnkle: begin
        span = (board_mode == ModeUpperLeg) ? 4 : 2;
        for (int k = 0; k < span; k++) begin
          if (idle_mask[k]) stop[k] = 1'b1;
          else m[k] = j[k];
        end
      end
      default: ;
    endcase

    // clamp only the motors in use
    used = int'(motor_count);
    if (used > int'(MotorSlots)) used = MotorSlots;
    if (used > int'(OutMotors)) used = OutMotors;
    lim = int'(pwm_limit);
    for (int k = 0; k < used; k++) begin
      if (m[k] > lim) m[k] = lim;
      if (m[k] < -lim) m[k] = -lim;
    end

    r.motor_pwm_0 = m[0][15:0];
    r.motor_pwm_1 = m[1][15:0];
    r.motor_pwm_2 = m[2][15:0];
    r.motor_pwm_3 = m[3][15:0];
    r.halt_mask   = stop;
    return r;
  endfunction

  task automatic report(string msg);
    fail_count_o++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_motor_cmd(out_item_t got);
    out_item_t want;
    if (motor_cmd_due.size() == 0) begin
      report($sformatf("motor command %h with none pending", got));
      return;
    end
    want = motor_cmd_due.pop_front();
    compare_field("motor_pwm_0", got.motor_pwm_0, want.motor_pwm_0);
    compare_field("motor_pwm_1", got.motor_pwm_1, want.motor_pwm_1);
    compare_field("motor_pwm_2", got.motor_pwm_2, want.motor_pwm_2);
    compare_field("motor_pwm_3", got.motor_pwm_3, want.motor_pwm_3);
    compare_field("halt_mask", 16'(got.halt_mask), 16'(want.halt_mask));
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_mode  = BoardModeRst;
      motor_count = MotorCountRst;
      pwm_limit   = PwmLimitRst;
      idle_mask   = '0;
      motor_cmd_due.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBoardMode:  board_mode  = cfg_data_i[2:0];
          CfgMotorCount: motor_count = cfg_data_i[2:0];
          CfgPwmLimit:   pwm_limit   = cfg_data_i[14:0];
          default: ;
        endcase
      end
      // drain before fill, so a result never matches its own item
      if (motor_i.valid === 1'b1 && motor_i.ready === 1'b1) check_motor_cmd(motor_i.payload);
      if (joint_i.valid === 1'b1 && joint_i.ready === 1'b1) begin
        if (joint_i.payload.opcode == OpCompute) begin
          motor_cmd_due.push_back(decouple_joints(joint_i.payload));
        end else begin
          idle_mask[joint_i.payload.motor_index] = joint_i.payload.motor_error;
        end
      end
      outstanding_o <= motor_cmd_due.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import jmpd_pkg::*;

  // Timing and run length
  localparam int ClkHalf     = 4;       // 8 ns period
  localparam int ResetCycles = 9;
  localparam int RandItems   = 1300;
  localparam int CalmItems   = 150;     // tail of the run with no idling
  localparam int DrainCycles = 6;       // covers the input and result registers
  localparam int LimitCycles = 200000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  outstanding;
  int                  cycle_count = 0;
  bit                  calm = 1'b0;

  jmpd_in_if  joint_ch ();
  jmpd_out_if motor_ch ();

  joint_to_motor_pwm_decoupler uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (joint_ch),
    .out_o      (motor_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Watches both channels and the register port, predicts and compares.
  motor_pwm_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .joint_i       (joint_ch),
    .motor_i       (motor_ch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #(ClkHalf) clk = 1'b1;
    #(ClkHalf) clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts, with open stretches
  // between them; none once the run goes calm.
  initial begin
    motor_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        motor_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      motor_ch.ready <= 1'b1;
    end
  end

  // --- item builders -------------------------------------------------------

  function automatic in_item_t make_compute(logic [15:0] j0, logic [15:0] j1,
                                            logic [15:0] j2, logic [15:0] j3,
                                            logic [2:0] stiff);
    in_item_t it;
    it.opcode      = OpCompute;
    it.motor_index = 2'($urandom);  // don't care on a compute transfer
    it.motor_error = 1'($urandom);
    it.joint_pwm_0 = j0;
    it.joint_pwm_1 = j1;
    it.joint_pwm_2 = j2;
    it.joint_pwm_3 = j3;
    it.stiff_0     = stiff[0];
    it.stiff_1     = stiff[1];
    it.stiff_2     = stiff[2];
    return it;
  endfunction

  function automatic in_item_t make_status(logic [1:0] motor, logic err);
    in_item_t    it;
    logic [95:0] noise;
    noise          = {$urandom, $urandom, $urandom};
    it             = noise[$bits(in_item_t)-1:0];
    it.opcode      = OpStatus;
    it.motor_index = motor;
    it.motor_error = err;
    return it;
  endfunction

  // Extremes and small values are favoured so that the clamp and the
  // 16-bit wrap of the shoulder terms are both hit often.
  function automatic logic [15:0] rand_joint();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return 16'($urandom_range(0, 800)) - 16'd400;
      default: return 16'($urandom);
    endcase
  endfunction

  // Status transfers are kept rare and mostly clear a bit, so the idle mask
  // is empty often enough for the coupling paths to be exercised.
  function automatic in_item_t rand_item();
    if ($urandom_range(0, 5) == 0)
      return make_status(2'($urandom), $urandom_range(0, 4) == 0);
    return make_compute(rand_joint(), rand_joint(), rand_joint(), rand_joint(),
                        3'($urandom));
  endfunction

  function automatic logic [2:0] pick_mode();
    case ($urandom_range(0, 8))
      0, 1, 2: return ModeShoulder;
      3, 4:    return ModeWaist;
      5:       return ModeUpperLeg;
      6:       return ModeAnkle;
      7:       return ModeNone;
      default: return 3'($urandom_range(5, 7));  // undefined modes act as none
    endcase
  endfunction

  function automatic logic [14:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 15'h7fff;
      1:       return '0;
      2:       return 15'($urandom_range(1, 300));
      default: return 15'($urandom);
    endcase
  endfunction

  // --- drivers -------------------------------------------------------------

  // One transfer on the joint channel, with an optional idle burst ahead of
  // it. valid is only lowered when a gap follows, never in the same step as
  // it is raised again.
  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      joint_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    joint_ch.valid   <= 1'b1;
    joint_ch.payload <= it;
    do @(posedge clk); while (joint_ch.ready !== 1'b1);
  endtask

  // Hold the sender off until every motor command has come back, then let
  // a status transfer still in the input register clear out.
  task automatic settle();
    joint_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Upper data bits are random on the narrow registers; the block keeps
  // only the low bits.
  task automatic load_config(logic [2:0] mode, logic [2:0] count, logic [14:0] limit);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgBoardMode;
    cfg_data <= {12'($urandom), mode};
    @(posedge clk);
    cfg_idx  <= CfgMotorCount;
    cfg_data <= {12'($urandom), count};
    @(posedge clk);
    cfg_idx  <= CfgPwmLimit;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // --- stimulus ------------------------------------------------------------

  task automatic run_directed();
    // reset mode is none: every output zero
    send_item(make_compute(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 3'b111));

    // shoulder, full limit: all stiff / none stiff at the extremes, mixed
    settle();
    load_config(ModeShoulder, 3'd4, 15'h7fff);
    send_item(make_compute(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 3'b111));
    send_item(make_compute(16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'b111));
    send_item(make_compute(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 3'b000));
    send_item(make_compute(16'd1000, -16'sd2000, 16'd3000, -16'sd4000, 3'b101));
    send_item(make_compute(-16'sd40, 16'd65, 16'd39, 16'hffff, 3'b010));
    // idle groups: shoulder group, then motor 3, then both cleared
    send_item(make_status(2'd0, 1'b1));
    send_item(make_compute(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 3'b000));
    send_item(make_status(2'd3, 1'b1));
    send_item(make_compute(16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'b111));
    send_item(make_status(2'd0, 1'b0));
    send_item(make_status(2'd3, 1'b0));

    // waist; motor count beyond the slots saturates
    settle();
    load_config(ModeWaist, 3'd7, 15'd100);
    send_item(make_compute(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 3'b000));
    send_item(make_compute(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 3'b111));
    send_item(make_compute(-16'sd3, 16'd0, -16'sd1, 16'd5, 3'b010));

    // upper leg, no motors in use: nothing clamped even at limit zero
    settle();
    load_config(ModeUpperLeg, 3'd0, 15'd0);
    send_item(make_compute(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 3'b000));
    send_item(make_status(2'd2, 1'b1));
    send_item(make_compute(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 3'b000));
    send_item(make_status(2'd2, 1'b0));

    // ankle with limit zero on the two used motors
    settle();
    load_config(ModeAnkle, 3'd2, 15'd0);
    send_item(make_compute(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 3'b000));

    // undefined board mode
    settle();
    load_config(3'd7, 3'd1, 15'd1);
    send_item(make_compute(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 3'b111));

    // limit one on three motors, motor 3 unclamped
    settle();
    load_config(ModeUpperLeg, 3'd3, 15'd1);
    send_item(make_compute(16'd5, -16'sd5, 16'd5, -16'sd5, 3'b000));
  endtask

  // Random phases, each under its own register setting; the block is drained
  // before every change of setting.
  task automatic run_random();
    int sent;
    int span;
    sent = 0;
    while (sent < RandItems) begin
      settle();
      load_config(pick_mode(), 3'($urandom_range(0, 7)), pick_limit());
      span = $urandom_range(40, 120);
      for (int k = 0; k < span && sent < RandItems; k++) begin
        calm = (sent >= RandItems - CalmItems);
        send_item(rand_item());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    joint_ch.valid   <= 1'b0;
    joint_ch.payload <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();
    settle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/jmpd_pkg.sv
hw/rtl/jmpd_if.sv
hw/rtl/joint_to_motor_pwm_decoupler.sv
tb/motor_pwm_checker.sv
tb/testbench.sv
